// ===== design/assert_macros.svh =====
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ===== design/mtd_pkg.sv =====
// Package: widths, status codes and shared types of the multiply-divide unit.
`default_nettype none
package mtd_pkg;
  localparam int OPERAND_WIDTH_DEF = 64;
  localparam int FIELD_W  = 64;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;
endpackage
`default_nettype wire

// ===== design/mtd_pipe.sv =====
// Pipelined 64x64 multiply followed by a bit-per-stage restoring divider.
`default_nettype none
module mtd_pipe #(
  parameter int W = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               in_valid,
  input  wire logic [W-1:0]       a,
  input  wire logic [W-1:0]       b,
  input  wire logic [W-1:0]       d,
  output logic                    res_valid,
  output logic [W-1:0]            res_q,
  output mtd_pkg::status_t        res_status
);
  import mtd_pkg::*;

  localparam int HW = (W + 1) / 2;
  localparam int NS = W + 3;

  // multiply stage 1: four half-width partial products
  logic          v1_r;
  logic [2*HW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic [W-1:0]  d1_r;
  logic [HW-1:0] al, ah, bl, bh;
  always_comb begin
    logic [2*HW-1:0] ax, bx;
    ax = {{(2*HW-W){1'b0}}, a};
    bx = {{(2*HW-W){1'b0}}, b};
    al = ax[HW-1:0];
    ah = ax[2*HW-1:HW];
    bl = bx[HW-1:0];
    bh = bx[2*HW-1:HW];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid;
    if (adv) begin
      p0_r <= al * bl;
      p1_r <= al * bh;
      p2_r <= ah * bl;
      p3_r <= ah * bh;
      d1_r <= d;
    end
  end

  // multiply stage 2: sum partial products, classify
  logic [2*W-1:0] rem_nxt;
  logic [4*HW-1:0] prod;
  always_comb begin
    prod = {{(2*HW){1'b0}}, p0_r}
         + ({{(2*HW){1'b0}}, p1_r} << HW)
         + ({{(2*HW){1'b0}}, p2_r} << HW)
         + ({p3_r, {(2*HW){1'b0}}});
    rem_nxt = prod[2*W-1:0];
  end

  // divider stages: one quotient bit per stage, hi in upper W bits
  logic           v_r  [NS];
  logic [2*W-1:0] hl_r [NS];
  logic [W-1:0]   dd_r [NS];
  logic [W-1:0]   q_r  [NS];
  status_t        st_r [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (adv) v_r[0] <= v1_r;
    if (adv) begin
      hl_r[0] <= rem_nxt;
      dd_r[0] <= d1_r;
      q_r[0]  <= '0;
      if (d1_r == '0) st_r[0] <= ST_DIV_ZERO;
      else if (rem_nxt[2*W-1:W] >= d1_r) st_r[0] <= ST_OVERFLOW;
      else st_r[0] <= ST_OK;
    end
  end

  for (genvar s = 0; s < W; s++) begin : g_div
    logic        carry;
    logic [W-1:0] hs;
    logic [W:0]   diff;
    always_comb begin
      carry = hl_r[s][2*W-1];
      hs    = hl_r[s][2*W-2:W-1];
      diff  = {carry, hs} - {1'b0, dd_r[s]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s+1] <= 1'b0;
      else if (adv) v_r[s+1] <= v_r[s];
      if (adv) begin
        dd_r[s+1] <= dd_r[s];
        st_r[s+1] <= st_r[s];
        if (!diff[W]) begin
          hl_r[s+1] <= {diff[W-1:0], hl_r[s][W-2:0], 1'b0};
          q_r[s+1]  <= {q_r[s][W-2:0], 1'b1};
        end else begin
          hl_r[s+1] <= {hs, hl_r[s][W-2:0], 1'b0};
          q_r[s+1]  <= {q_r[s][W-2:0], 1'b0};
        end
      end
    end
  end

  // last two stages are depth slack beyond W; they only carry the beat along
  for (genvar s = W + 1; s < NS; s++) begin : g_pad
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s] <= 1'b0;
      else if (adv) v_r[s] <= v_r[s-1];
      if (adv) begin
        hl_r[s] <= hl_r[s-1];
        dd_r[s] <= dd_r[s-1];
        q_r[s]  <= q_r[s-1];
        st_r[s] <= st_r[s-1];
      end
    end
  end

  assign res_valid  = v_r[NS-1];
  assign res_status = st_r[NS-1];
  assign res_q      = (st_r[NS-1] == ST_OK) ? q_r[NS-1] : '1;
endmodule
`default_nettype wire

// ===== design/multiply_then_divide_64.sv =====
// Top level: streaming floor(a*b/d) unit with saturating error status.
`default_nettype none
// Channel | dir | tdata fields (low bit up)                        | tuser
// in_     | in  | factor_a[63:0], factor_b[127:64], divisor[191:128] | -
// out_    | out | quotient[63:0]                                    | status[1:0]
//
// One beat per cycle sustained while the output is not stalled. Stages:
// two multiply stages, one restoring-divide stage per quotient bit,
// two pad stages, and the output register.
// Synchronous active-low reset clears all valid bits; data is not reset.
// A stall on out_tready freezes the whole pipeline together; when the
// output register is empty the pipe keeps moving and fills it.
module multiply_then_divide_64 #(
  parameter int OPERAND_WIDTH = mtd_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [191:0] in_tdata,   // factor_a, factor_b, divisor
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // quotient
  output logic [1:0]        out_tuser   // status
);
  import mtd_pkg::*;

  localparam int W = OPERAND_WIDTH;

  logic          adv;
  logic          res_valid;
  logic [W-1:0]  res_q;
  status_t       res_status;
  logic          ov_r;
  logic [W-1:0]  oq_r;
  status_t       os_r;

  // pipe advances whenever the output slot is free or being drained
  assign adv       = !ov_r || out_tready;
  assign in_tready = adv;

  mtd_pipe #(.W(W)) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_tvalid),
    .a          (in_tdata[W-1:0]),
    .b          (in_tdata[FIELD_W+W-1:FIELD_W]),
    .d          (in_tdata[2*FIELD_W+W-1:2*FIELD_W]),
    .res_valid  (res_valid),
    .res_q      (res_q),
    .res_status (res_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= res_valid;
    if (adv) begin
      oq_r <= res_q;
      os_r <= res_status;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(FIELD_W-W){1'b0}}, oq_r};
  assign out_tuser  = os_r;
endmodule
`default_nettype wire

// ===== design/mtd_checker.sv =====
// Port-level checker for the multiply-divide unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module mtd_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [63:0]  out_tdata,
  input wire logic [1:0]   out_tuser
);
  import mtd_pkg::*;

  `CHK_IMPLY(a_no_code3, clk, rst_n, out_tvalid, out_tuser <= ST_OVERFLOW)
  `CHK_IMPLY(a_err_ones, clk, rst_n, out_tvalid && out_tuser != ST_OK, &out_tdata[7:0])
  `CHK_IMPLY(a_ready_free, clk, rst_n, !out_tvalid, in_tready)
  `CHK_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind multiply_then_divide_64 mtd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
`default_nettype wire

// ===== tb/multiply_then_divide_64_test.sv =====
// Testbench for multiply_then_divide_64: directed table plus random beats, scoreboard checked.
`default_nettype none
module multiply_then_divide_64_test;
  import mtd_pkg::*;

  localparam int LATENCY = 64 + 5;
  localparam int N_RANDOM = 1330;

  typedef struct packed {
    logic [63:0] factor_a;
    logic [63:0] factor_b;
    logic [63:0] divisor;
  } operands_t;

  typedef struct packed {
    logic [63:0] quotient;
    status_t     status;
  } muldiv_result_t;

  // directed row: operands, and a typed-in expectation where one is obvious
  typedef struct {
    operands_t      ops;
    logic           known;
    muldiv_result_t res;
  } row_t;

  localparam logic [63:0] ONES = {64{1'b1}};
  localparam logic [63:0] TOP  = 64'h8000_0000_0000_0000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [191:0] in_tdata;   // factor_a, factor_b, divisor
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;  // quotient
  logic [1:0]   out_tuser;  // status

  muldiv_result_t expected_q[$];
  int unsigned    mismatches;
  int unsigned    beats_in;
  int unsigned    beats_out;
  int unsigned    n_div_zero;
  int unsigned    n_overflow;
  bit             stim_done;
  bit             long_hold;

  multiply_then_divide_64 u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Exact floor(a*b/d) on the full 128-bit product, saturating on error.
  function automatic muldiv_result_t muldiv_predict(operands_t op);
    logic [127:0]   prod;
    logic [127:0]   quo;
    muldiv_result_t r;
    prod = op.factor_a * op.factor_b;
    if (op.divisor == '0) begin
      r.quotient = ONES;
      r.status   = ST_DIV_ZERO;
    end else begin
      quo = prod / {64'd0, op.divisor};
      if (quo[127:64] != '0) begin
        r.quotient = ONES;
        r.status   = ST_OVERFLOW;
      end else begin
        r.quotient = quo[63:0];
        r.status   = ST_OK;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("MISMATCH beat %0d %s: got %h want %h", beats_out, what, got, want);
  endtask

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // operand with a shape chosen at random: full, small, near a power of two, edges
  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    int          sh;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: v = v >> $urandom_range(63);
      1: v = 64'd1 << $urandom_range(63);
      2: begin
        sh = $urandom_range(63);
        v = (64'd1 << sh) - $urandom_range(2);
      end
      3: v = ONES - $urandom_range(3);
      4: v = $urandom_range(7);
      default: ;
    endcase
    return v;
  endfunction

  function automatic operands_t rand_ops();
    operands_t o;
    logic [127:0] prod;
    o.factor_a = rand_operand();
    o.factor_b = rand_operand();
    case ($urandom_range(9))
      0: o.divisor = '0;
      1, 2, 3: begin
        // divisor at or just above the high half of the product puts the quotient near the overflow edge
        prod = o.factor_a * o.factor_b;
        o.divisor = prod[127:64] + $urandom_range(3);
      end
      default: o.divisor = rand_operand();
    endcase
    return o;
  endfunction

  task automatic send_beat(operands_t op);
    in_tvalid <= 1'b1;
    in_tdata  <= {op.divisor, op.factor_b, op.factor_a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(muldiv_predict(op));
    beats_in++;
  endtask

  task automatic idle_input(int n);
    if (n == 0) return;
    in_tvalid <= 1'b0;
    in_tdata  <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    repeat (n) @(posedge clk);
  endtask

  // Directed table, then random beats.
  initial begin
    row_t           rows[$];
    row_t           rw;
    operands_t      op;
    muldiv_result_t pr;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    mismatches = 0;
    beats_in   = 0;
    beats_out  = 0;
    n_div_zero = 0;
    n_overflow = 0;
    stim_done  = 0;
    long_hold  = 0;

    // extremes and error codes with expectations typed in; others predicted
    rows.push_back('{'{64'd0, 64'd0, 64'd1}, 1, '{64'd0, ST_OK}});
    rows.push_back('{'{64'd0, 64'd0, 64'd0}, 1, '{ONES, ST_DIV_ZERO}});
    rows.push_back('{'{ONES, ONES, 64'd0}, 1, '{ONES, ST_DIV_ZERO}});
    rows.push_back('{'{ONES, ONES, ONES}, 1, '{ONES, ST_OK}});
    rows.push_back('{'{ONES, ONES, 64'd1}, 1, '{ONES, ST_OVERFLOW}});
    rows.push_back('{'{ONES, 64'd1, 64'd1}, 1, '{ONES, ST_OK}});
    rows.push_back('{'{TOP, 64'd2, 64'd1}, 1, '{ONES, ST_OVERFLOW}});
    rows.push_back('{'{TOP, 64'd2, 64'd2}, 1, '{TOP, ST_OK}});
    rows.push_back('{'{ONES, 64'd2, 64'd2}, 1, '{ONES, ST_OK}});
    rows.push_back('{'{ONES, 64'd2, 64'd1}, 1, '{ONES, ST_OVERFLOW}});
    rows.push_back('{'{64'd7, 64'd6, 64'd5}, 1, '{64'd8, ST_OK}});
    rows.push_back('{'{64'd1, 64'd1, ONES}, 1, '{64'd0, ST_OK}});
    rows.push_back('{'{ONES, ONES, ONES - 1}, 0, '{'0, ST_OK}});
    rows.push_back('{'{ONES, ONES - 1, ONES}, 0, '{'0, ST_OK}});
    rows.push_back('{'{TOP, TOP, TOP}, 1, '{TOP, ST_OK}});
    rows.push_back('{'{TOP, TOP, TOP - 1}, 0, '{'0, ST_OK}});
    // moda*modb-wrap territory of the split algorithm
    rows.push_back('{'{64'hFFFF_FFFF_0000_0001, 64'hFFFF_FFFF_0000_0003,
                       64'hFFFF_FFFF_0000_0007}, 0, '{'0, ST_OK}});
    rows.push_back('{'{64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321,
                       64'h1000_0000_0000_0000}, 0, '{'0, ST_OK}});
    rows.push_back('{'{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                       64'h5555_5555_5555_5556}, 0, '{'0, ST_OK}});
    rows.push_back('{'{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                       64'h3333_3333_3333_3333}, 0, '{'0, ST_OK}});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      rw = rows[i];
      pr = muldiv_predict(rw.ops);
      if (rw.known && pr != rw.res)
        report_mismatch($sformatf("table row %0d", i), pr.quotient, rw.res.quotient);
      send_beat(rw.ops);
      idle_input(i % 3 == 0 ? 0 : gap_len());
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      op = rand_ops();
      send_beat(op);
      // bursts without gaps for a stretch, gaps elsewhere
      if ((n / 100) % 3 != 1) idle_input(gap_len());
      if (n == 400) long_hold = 1;
    end
    in_tvalid <= 1'b0;
    stim_done = 1;
  end

  // Receiver: random backpressure, plus one long hold-off while input keeps coming.
  initial begin
    int hold;
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        long_hold = 0;
        out_tready <= 1'b0;
        repeat (3 * LATENCY) @(posedge clk);
      end
      hold = ($urandom_range(3) == 0) ? gap_len() : 0;
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Scoreboard: compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    muldiv_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, '0);
      end else begin
        want = expected_q.pop_front();
        if (out_tdata !== want.quotient)
          report_mismatch("quotient", out_tdata, want.quotient);
        if (out_tuser !== want.status)
          report_mismatch("status", {62'd0, out_tuser}, {62'd0, want.status});
        if (want.status == ST_DIV_ZERO) n_div_zero++;
        if (want.status == ST_OVERFLOW) n_overflow++;
      end
    end
  end

  // End of run: drain, let the pipe settle, then report.
  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (expected_q.size() != 0) begin
      mismatches++;
      $display("%0d predictions left unmatched", expected_q.size());
    end
    $display("Covered %0d beats in, %0d out: %0d divide-by-zero, %0d overflow.",
             beats_in, beats_out, n_div_zero, n_overflow);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("Timeout");
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ===== multiply_then_divide_64.f =====
+incdir+design
design/mtd_pkg.sv
design/mtd_pipe.sv
design/multiply_then_divide_64.sv
design/mtd_checker.sv
tb/multiply_then_divide_64_test.sv
